>>> hdl/wildcard_to_regex_translator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the wildcard-to-regex translator core
// Property helpers sampled on clock, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_TO_REGEX_TRANSLATOR_CORE_DEFINES_SVH
`define WILDCARD_TO_REGEX_TRANSLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define W2R_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("w2r assertion failed");

// Next-cycle implication
`define W2R_ASSERT_NXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("w2r assertion failed");

`else

`define W2R_ASSERT_IMP(label, cond, prop)
`define W2R_ASSERT_NXT(label, cond, prop)

`endif

`endif

>>> hdl/w2r_pkg.sv
// ---------------------------------------------------------------------------
// w2r_pkg
// Shared types, character constants and helpers of the translator core.
// ---------------------------------------------------------------------------
package w2r_pkg;

   // Queue depth between front and back end
   localparam int QUEUE_DEPTH = 4;

   // Operation codes of the input word
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Characters with a special meaning
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_DIGIT   = 2'd1,
      STATUS_TRAIL_BSLASH = 2'd2,
      STATUS_UNTERM      = 2'd3
   } status_type;

   // Translation mode, one-hot
   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_ESCAPE = 6'b000010,
      MODE_DOTRUN = 6'b000100,
      MODE_QMIN   = 6'b001000,
      MODE_QMAX   = 6'b010000,
      MODE_DROP   = 6'b100000
   } mode_type;

   // One queued command: a single result word, or backslash plus character
   typedef struct packed {
      logic       pair;
      logic       has_char;
      logic [7:0] ch;
      status_type status;
   } entry_type;

   // True for regex metacharacters that need a backslash
   function automatic logic is_meta(input logic [7:0] c);
      logic r;
      unique case (c)
         8'h24, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h3F,
         8'h5B, 8'h5D, 8'h5E, 8'h7B, 8'h7C, 8'h7D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/wildcard_to_regex_translator_core.sv
// The first result word of an item passes through the command queue and the output register.
// The output register gives one result word per cycle while rsp_ready holds, so an item that
// yields backslash plus character gives its backslash word first and its character word after it.
// Items that yield no word (lone backslash, dropped characters) take no queue entry.
// Reset clears the mode, the error code, the command queue and the output valid.
// ---------------------------------------------------------------------------
// wildcard_to_regex_translator_core
// Wildcard pattern to regex translator: front end, command queue, back end.
// ---------------------------------------------------------------------------
`include "wildcard_to_regex_translator_core_defines.svh"

module wildcard_to_regex_translator_core #(
   parameter int QUEUE_DEPTH = w2r_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_in_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_char,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_status,
   output logic       rsp_run_last
);
   import w2r_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // Classify incoming words
   w2r_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_in_char   (req_in_char),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   // Decouple front and back
   w2r_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Expand commands into result words
   w2r_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_has_char (rsp_has_char),
      .rsp_out_char (rsp_out_char),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

   // A word that is not the last of its item is always the escaping backslash
   `W2R_ASSERT_IMP(a_first_is_bslash, rsp_valid && !rsp_run_last, rsp_has_char && rsp_out_char == CHAR_BSLASH && rsp_status == STATUS_OK)

   // An error status carries no character and closes its item
   `W2R_ASSERT_IMP(a_status_no_char, rsp_valid && rsp_status != STATUS_OK, !rsp_has_char && rsp_run_last)

   // The second half of a pair follows right after the first is taken
   `W2R_ASSERT_NXT(a_pair_follows, rsp_valid && rsp_ready && !rsp_run_last, rsp_valid && rsp_run_last && rsp_has_char)

endmodule

>>> hdl/w2r_front.sv
// ---------------------------------------------------------------------------
// w2r_front
// Accepts pattern words, tracks the translation mode and queues commands.
// ---------------------------------------------------------------------------
module w2r_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [7:0]         req_in_char,
   output logic               push_valid,
   input  logic               push_ready,
   output w2r_pkg::entry_type push_entry
);
   import w2r_pkg::*;

   mode_type   mode_ff, mode_in;
   status_type error_ff, error_in;
   logic       emit;
   logic       accept;
   logic       is_digit;

   assign req_ready  = push_ready;
   assign accept     = req_valid & push_ready;
   assign push_valid = req_valid & emit;
   assign is_digit   = (req_in_char >= CHAR_ZERO) && (req_in_char <= CHAR_NINE);

   // Classify the incoming word against the current mode
   always_comb begin
      mode_in             = mode_ff;
      error_in            = error_ff;
      emit                = 1'b1;
      push_entry.pair     = 1'b0;
      push_entry.has_char = 1'b1;
      push_entry.ch       = req_in_char;
      push_entry.status   = STATUS_OK;
      if (req_operation == OP_END) begin
         push_entry.has_char = 1'b0;
         push_entry.ch       = 8'h00;
         if (error_ff != STATUS_OK) begin
            push_entry.status = error_ff;
         end else if (mode_ff == MODE_ESCAPE) begin
            push_entry.status = STATUS_TRAIL_BSLASH;
         end else if (mode_ff == MODE_QMIN || mode_ff == MODE_QMAX) begin
            push_entry.status = STATUS_UNTERM;
         end
         mode_in  = MODE_NORMAL;
         error_in = STATUS_OK;
      end else begin
         unique case (mode_ff)
            MODE_DROP: begin
               emit = 1'b0;
            end
            MODE_ESCAPE: begin
               push_entry.pair = 1'b1;
               mode_in         = MODE_NORMAL;
            end
            MODE_DOTRUN: begin
               if (req_in_char == CHAR_DOT) begin
                  mode_in = MODE_DOTRUN;
               end else if (req_in_char == CHAR_LBRACE) begin
                  mode_in = MODE_QMIN;
               end else begin
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_QMIN, MODE_QMAX: begin
               if ((mode_ff == MODE_QMIN && req_in_char == CHAR_COMMA) ||
                   (mode_ff == MODE_QMAX && req_in_char == CHAR_RBRACE)) begin
                  mode_in = (mode_ff == MODE_QMIN) ? MODE_QMAX : MODE_NORMAL;
               end else if (!is_digit) begin
                  push_entry.has_char = 1'b0;
                  push_entry.ch       = 8'h00;
                  push_entry.status   = STATUS_BAD_DIGIT;
                  error_in            = STATUS_BAD_DIGIT;
                  mode_in             = MODE_DROP;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
               if (req_in_char == CHAR_DOT) begin
                  mode_in = MODE_DOTRUN;
               end else if (req_in_char == CHAR_BSLASH) begin
                  mode_in = MODE_ESCAPE;
                  emit    = 1'b0;
               end else if (is_meta(req_in_char)) begin
                  push_entry.pair = 1'b1;
               end
            end
         endcase
      end
   end

   // Advance mode and error on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         error_ff <= STATUS_OK;
      end else if (accept) begin
         mode_ff  <= mode_in;
         error_ff <= error_in;
      end
   end

endmodule

>>> hdl/w2r_fifo.sv
// ---------------------------------------------------------------------------
// w2r_fifo
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module w2r_fifo #(
   parameter int DEPTH = w2r_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  w2r_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output w2r_pkg::entry_type pop_entry
);
   import w2r_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_entry  = store_ff[rd_ptr_ff];

   // Wrap pointers at the depth
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Write entries
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/w2r_back.sv
// ---------------------------------------------------------------------------
// w2r_back
// Expands queued commands into result words through an output register.
// ---------------------------------------------------------------------------
module w2r_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  w2r_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_has_char,
   output logic [7:0]         rsp_out_char,
   output logic [1:0]         rsp_status,
   output logic               rsp_run_last
);
   import w2r_pkg::*;

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic       has_ff, has_in;
   logic [7:0] char_ff, char_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;

   assign load      = !valid_ff || rsp_ready;
   assign pop_ready = load && (second_ff || !pop_entry.pair);

   // Pick the next result word from the queue head
   always_comb begin
      valid_in  = 1'b0;
      second_in = second_ff;
      has_in    = pop_entry.has_char;
      char_in   = pop_entry.ch;
      status_in = pop_entry.status;
      last_in   = 1'b1;
      if (pop_valid) begin
         valid_in = 1'b1;
         if (second_ff) begin
            has_in    = 1'b1;
            status_in = STATUS_OK;
            second_in = 1'b0;
         end else if (pop_entry.pair) begin
            has_in    = 1'b1;
            char_in   = CHAR_BSLASH;
            status_in = STATUS_OK;
            last_in   = 1'b0;
            second_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else if (load) begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (load) begin
         has_ff    <= has_in;
         char_ff   <= char_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_has_char = has_ff;
   assign rsp_out_char = char_ff;
   assign rsp_status   = status_ff;
   assign rsp_run_last = last_ff;

endmodule
